// ===== hdl/bst_pkg.sv =====
// bst_pkg: shared types and constants for the bounded set table.
// Holds operation codes, default sizes and the controller command word.
// No dependencies.
package bst_pkg;

  localparam int BST_CAPACITY      = 16;
  localparam int BST_ELEMENT_WIDTH = 32;
  localparam int BST_MODE_W        = 2;
  localparam int BST_VALUE_W       = 32;
  localparam int BST_COUNT_OUT_W   = 5;

  typedef enum logic [BST_MODE_W-1:0] {
    MODE_QUERY  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } bst_mode_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } bst_cmd_t;

endpackage

// ===== hdl/bst_ctrl.sv =====
// bst_ctrl: controller state machine for the bounded set table.
// Sequences capture and commit of one word; depends on bst_pkg.
module bst_ctrl
  import bst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output bst_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.capture   = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held past one cycle");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("missing result strobe");

endmodule

// ===== hdl/bst_datapath.sv =====
// bst_datapath: element cells, per-cell compare, shift and result registers.
// Driven by bst_ctrl commands; depends on bst_pkg.
module bst_datapath
  import bst_pkg::*;
#(
  parameter int CAPACITY      = BST_CAPACITY,
  parameter int ELEMENT_WIDTH = BST_ELEMENT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bst_cmd_t                   cmd,
  input  logic [BST_MODE_W-1:0]      in_mode,
  input  logic [BST_VALUE_W-1:0]     in_value,
  output logic                       out_was_member,
  output logic [BST_COUNT_OUT_W-1:0] out_count,
  output logic                       out_is_empty,
  output logic                       out_is_full,
  output logic                       out_rejected
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EXT_W = (ELEMENT_WIDTH > BST_VALUE_W) ? ELEMENT_WIDTH : BST_VALUE_W;
  localparam int CWD_W = (CNT_W > BST_COUNT_OUT_W) ? CNT_W : BST_COUNT_OUT_W;

  logic [ELEMENT_WIDTH-1:0] store_r [CAPACITY];
  logic [CAPACITY-1:0]      hit_r, hit_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [BST_MODE_W-1:0]    mode_r;
  logic [ELEMENT_WIDTH-1:0] value_r;
  logic [EXT_W-1:0]         value_ext;
  logic [ELEMENT_WIDTH-1:0] elem;

  logic                     member;
  logic [IDX_W-1:0]         slot;
  logic                     do_ins, do_del, rej;
  logic [CWD_W-1:0]         count_wide;

  logic                       was_member_r;
  logic [BST_COUNT_OUT_W-1:0] count_out_r;
  logic                       is_empty_r, is_full_r, rejected_r;

  assign value_ext = EXT_W'(in_value);
  assign elem      = value_ext[ELEMENT_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit_nxt[i] = (CNT_W'(i) < count_r) && (store_r[i] == elem);
    end
  end

  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot = slot | (hit_r[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

  assign member = |hit_r;
  assign do_ins = (mode_r == MODE_INSERT) && !member && (count_r != CNT_W'(CAPACITY));
  assign rej    = (mode_r == MODE_INSERT) && !member && (count_r == CNT_W'(CAPACITY));
  assign do_del = (mode_r == MODE_DELETE) && member;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_wide = CWD_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_r   <= hit_nxt;
      mode_r  <= in_mode;
      value_r <= elem;
    end
    if (cmd.commit) begin
      was_member_r <= member;
      count_out_r  <= count_wide[BST_COUNT_OUT_W-1:0];
      is_empty_r   <= (count_nxt == '0);
      is_full_r    <= (count_nxt == CNT_W'(CAPACITY));
      rejected_r   <= rej;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic shift_here, ins_here;
    assign shift_here = do_del && (IDX_W'(g) >= slot) && (g < CAPACITY - 1);
    assign ins_here   = do_ins && (count_r == CNT_W'(g));
    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        if (shift_here) begin
          store_r[g] <= store_r[(g < CAPACITY - 1) ? g + 1 : g];
        end else if (ins_here) begin
          store_r[g] <= value_r;
        end
      end
    end
  end

  assign out_was_member = was_member_r;
  assign out_count      = count_out_r;
  assign out_is_empty   = is_empty_r;
  assign out_is_full    = is_full_r;
  assign out_rejected   = rejected_r;

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(hit_r))
    else $error("value matched in more than one cell");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("count moved outside commit");

endmodule

// ===== hdl/bounded_set_table.sv =====
// bounded_set_table: set of distinct values packed in a row of cells, with count.
// The accepting edge captures the per-cell compare; the update state then commits/shifts the
// cell row and registers the result strobe. busy holds off a new word until the update is done.
// Reset (synchronous, rst_n low) empties the set; cell contents are not cleared.
// The receiver cannot stall: out_valid is high for exactly one cycle per word.
module bounded_set_table
  import bst_pkg::*;
#(
  parameter int CAPACITY      = BST_CAPACITY,
  parameter int ELEMENT_WIDTH = BST_ELEMENT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [BST_MODE_W-1:0]      in_mode,
  input  logic [BST_VALUE_W-1:0]     in_value,
  output logic                       out_valid,
  output logic                       out_was_member,
  output logic [BST_COUNT_OUT_W-1:0] out_count,
  output logic                       out_is_empty,
  output logic                       out_is_full,
  output logic                       out_rejected
);

  bst_cmd_t cmd;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bst_datapath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .out_was_member (out_was_member),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_rejected   (out_rejected)
  );

endmodule

// ===== bench/bounded_set_table_tb.sv =====
// bounded_set_table_tb: self-checking bench for the bounded set table.
// Drives query/insert/delete/unused words, predicts each result, checks every strobe.
// Depends on bst_pkg and bounded_set_table.
`timescale 1ns / 100ps

module bounded_set_table_tb;
  import bst_pkg::*;

  localparam logic [BST_MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE   = 20;

  typedef struct packed {
    logic                       was_member;
    logic [BST_COUNT_OUT_W-1:0] count;
    logic                       is_empty;
    logic                       is_full;
    logic                       rejected;
  } set_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [BST_MODE_W-1:0]      in_mode;
  logic [BST_VALUE_W-1:0]     in_value;
  logic                       out_valid;
  logic                       out_was_member;
  logic [BST_COUNT_OUT_W-1:0] out_count;
  logic                       out_is_empty;
  logic                       out_is_full;
  logic                       out_rejected;

  logic [BST_ELEMENT_WIDTH-1:0] set_members[$];
  set_result_t                  pending_results[$];
  set_result_t                  oldest;
  logic [BST_VALUE_W-1:0]       value_pool[POOL_SIZE];
  int                           mismatch_count;
  int                           stall_cycles;

  bounded_set_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_was_member(out_was_member),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_is_full   (out_is_full),
    .out_rejected  (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic set_result_t apply_set_op(logic [BST_MODE_W-1:0] mode,
                                               logic [BST_VALUE_W-1:0] value);
    logic [BST_ELEMENT_WIDTH-1:0] elem;
    int                           slot;
    set_result_t                  res;
    elem = value[BST_ELEMENT_WIDTH-1:0];
    slot = -1;
    res  = '0;
    foreach (set_members[i]) begin
      if (slot < 0 && set_members[i] == elem) slot = i;
    end
    res.was_member = (slot >= 0);
    if (mode == MODE_INSERT && slot < 0) begin
      if (set_members.size() >= BST_CAPACITY) res.rejected = 1'b1;
      else set_members.push_back(elem);
    end else if (mode == MODE_DELETE && slot >= 0) begin
      set_members.delete(slot);
    end
    res.count    = BST_COUNT_OUT_W'(set_members.size());
    res.is_empty = (set_members.size() == 0);
    res.is_full  = (set_members.size() == BST_CAPACITY);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) pending_results.push_back(apply_set_op(in_mode, in_value));
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, count", 32'(out_count), 32'd0);
        end else begin
          oldest = pending_results.pop_front();
          if (out_was_member !== oldest.was_member)
            report_mismatch("was_member", 32'(out_was_member), 32'(oldest.was_member));
          if (out_count !== oldest.count)
            report_mismatch("count", 32'(out_count), 32'(oldest.count));
          if (out_is_empty !== oldest.is_empty)
            report_mismatch("is_empty", 32'(out_is_empty), 32'(oldest.is_empty));
          if (out_is_full !== oldest.is_full)
            report_mismatch("is_full", 32'(out_is_full), 32'(oldest.is_full));
          if (out_rejected !== oldest.rejected)
            report_mismatch("rejected", 32'(out_rejected), 32'(oldest.rejected));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("** bounded_set_table: FAILED **");
        $finish;
      end
    end
  end

  // hold start high until the word is taken; return just after the accepting edge
  task automatic send_word(logic [BST_MODE_W-1:0] mode, logic [BST_VALUE_W-1:0] value);
    @(negedge clk);
    start    <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_sender(int cycles);
    @(negedge clk);
    start    <= 1'b0;
    in_mode  <= BST_MODE_W'($urandom);
    in_value <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic run_random(int words, int insert_pct, int delete_pct, bit allow_idle);
    int                     pick;
    bit                     idle_on;
    logic [BST_MODE_W-1:0]  mode;
    logic [BST_VALUE_W-1:0] value;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = '0;
    value_pool[1] = '1;
    idle_on = allow_idle;
    for (int n = 0; n < words; n++) begin
      if (allow_idle && n % 50 == 0) idle_on = 1'($urandom_range(0, 1));
      if (idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 19));
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) mode = MODE_INSERT;
      else if (pick < insert_pct + delete_pct) mode = MODE_DELETE;
      else if (pick < 95) mode = MODE_QUERY;
      else mode = MODE_UNUSED;
      if ($urandom_range(0, 9) == 0) value = $urandom;
      else value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_word(mode, value);
    end
  endtask

  task automatic test_empty_set();
    send_word(MODE_QUERY, 32'h0000_0000);
    send_word(MODE_DELETE, 32'hFFFF_FFFF);
    send_word(MODE_UNUSED, 32'h0000_0000);
  endtask

  task automatic test_fill_and_reject();
    send_word(MODE_INSERT, 32'h0000_0000);
    send_word(MODE_INSERT, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 32'h0000_0000);
    for (int i = 1; i <= BST_CAPACITY - 2; i++) send_word(MODE_INSERT, 32'hA5A5_0000 + i);
    send_word(MODE_INSERT, 32'h5A5A_5A5A);
    send_word(MODE_INSERT, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'hA5A5_0003);
  endtask

  task automatic test_delete_positions();
    send_word(MODE_DELETE, 32'hA5A5_0007);
    send_word(MODE_DELETE, 32'h0000_0000);
    send_word(MODE_DELETE, 32'hA5A5_000E);
    send_word(MODE_DELETE, 32'h1234_5678);
    send_word(MODE_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_fill();
    run_random(400, 60, 15, 1'b1);
  endtask

  task automatic test_random_drain();
    run_random(300, 15, 60, 1'b1);
  endtask

  task automatic test_random_mixed();
    run_random(800, 40, 30, 1'b1);
  endtask

  task automatic test_random_no_idle();
    run_random(400, 40, 35, 1'b0);
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = MODE_QUERY;
    in_value       = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_set();
    test_fill_and_reject();
    test_delete_positions();
    test_random_fill();
    test_random_drain();
    test_random_mixed();
    test_random_no_idle();

    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** bounded_set_table: PASSED **");
    end else begin
      $display("** bounded_set_table: FAILED **");
    end
    $finish;
  end

endmodule
